// ===== rtl/cles_pkg.sv =====
// Shared types, constants and helper functions of the charlieplex LED effect sequencer.
package cles_pkg;

  localparam logic [7:0] LOW_LEVEL  = 8'd20;
  localparam logic [7:0] FULL_LEVEL = 8'd255;
  localparam logic [2:0] FIRST_LED  = 3'd1;
  localparam logic [2:0] LAST_LED   = 3'd6;
  localparam logic [2:0] SNAKE_TURN = 3'd5;
  localparam logic [2:0] SNAKE_STOP = 3'd2;

  localparam int ApbAddrWidth = 4;
  localparam int ApbDataWidth = 32;

  typedef enum logic [1:0] {
    MODE_BLINK  = 2'd0,
    MODE_SNAKE  = 2'd1,
    MODE_XFADE  = 2'd2,
    MODE_CIRCLE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_STEP   = 2'd1,
    REG_DELAY  = 2'd2,
    REG_CIRCLE = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    DRV_HIZ = 2'd0,
    DRV_LOW = 2'd1,
    DRV_PWM = 2'd2
  } drive_t;

  typedef struct packed {
    drive_t a;
    drive_t b;
    drive_t c;
  } pins_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  level_step;
    logic [15:0] delay_ticks;
    logic [7:0]  circle_level;
    logic        mode_wr;    // effect_mode written this cycle
    mode_t       mode_new;   // value being written
  } cfg_t;

  typedef struct packed {
    logic [15:0] countdown;
    logic        section;    // snake: 0 forward, 1 backward
    logic [2:0]  led;
    logic [7:0]  level;
    logic        rising;
    logic        second;     // cross-fade: next LED's half is due
  } seq_state_t;

  typedef struct packed {
    logic [2:0] segment_index;
    logic [7:0] duty;
    pins_t      pins;
    logic       pass_end;
  } result_t;

  function automatic seq_state_t restart_state(mode_t m);
    seq_state_t st;
    st.countdown = 16'd0;
    st.section   = 1'b0;
    st.led       = FIRST_LED;
    st.level     = (m == MODE_XFADE) ? FULL_LEVEL : LOW_LEVEL;
    st.rising    = 1'b1;
    st.second    = 1'b0;
    return st;
  endfunction

  function automatic pins_t pin_map(logic [2:0] led);
    pins_t p;
    case (led)
      3'd2:    p = '{DRV_PWM, DRV_LOW, DRV_HIZ};
      3'd3:    p = '{DRV_HIZ, DRV_LOW, DRV_PWM};
      3'd4:    p = '{DRV_HIZ, DRV_PWM, DRV_LOW};
      3'd5:    p = '{DRV_LOW, DRV_HIZ, DRV_PWM};
      3'd6:    p = '{DRV_PWM, DRV_HIZ, DRV_LOW};
      default: p = '{DRV_LOW, DRV_PWM, DRV_HIZ};
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/cles_regs.sv =====
// APB configuration register bank of the LED effect sequencer.
module cles_regs
  import cles_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output logic [ApbDataWidth-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  mode_t       mode;
  logic [7:0]  level_step;
  logic [15:0] delay_ticks;
  logic [7:0]  circle_level;
  reg_idx_t    idx;
  logic        wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_XFADE;
      level_step   <= 8'd1;
      delay_ticks  <= 16'd2;
      circle_level <= FULL_LEVEL;
    end else if (wr) begin
      unique case (idx)
        REG_MODE:   mode         <= mode_t'(pwdata[1:0]);
        REG_STEP:   level_step   <= pwdata[7:0];
        REG_DELAY:  delay_ticks  <= pwdata[15:0];
        REG_CIRCLE: circle_level <= pwdata[7:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:   prdata = {30'd0, mode};
      REG_STEP:   prdata = {24'd0, level_step};
      REG_DELAY:  prdata = {16'd0, delay_ticks};
      REG_CIRCLE: prdata = {24'd0, circle_level};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    cfg.mode         = mode;
    cfg.level_step   = level_step;
    cfg.delay_ticks  = delay_ticks;
    cfg.circle_level = circle_level;
    cfg.mode_wr      = wr && (idx == REG_MODE);
    cfg.mode_new     = mode_t'(pwdata[1:0]);
  end

endmodule

// ===== rtl/cles_step.sv =====
// Combinational tick logic: countdown, effect sequencing and step result.
module cles_step
  import cles_pkg::*;
(
  input  seq_state_t cur,
  input  cfg_t       cfg,
  input  logic       restart,
  output seq_state_t nxt,
  output logic       fire,
  output result_t    res
);

  seq_state_t st;
  logic [7:0] s;
  logic [8:0] low_s;
  logic [8:0] sum;
  logic [2:0] led;
  logic [2:0] led_wrap;
  logic [7:0] lvl;
  logic       fall_end;
  logic [7:0] adv_level;
  logic       adv_rising;
  logic       adv_done;
  logic [2:0] out_led;
  logic [7:0] out_duty;
  logic       out_end;

  always_comb begin
    st       = restart ? restart_state(cfg.mode) : cur;
    s        = (cfg.level_step == 8'd0) ? 8'd1 : cfg.level_step;
    low_s    = {1'b0, LOW_LEVEL} + {1'b0, s};
    led      = (st.led < FIRST_LED || st.led > LAST_LED) ? FIRST_LED : st.led;
    led_wrap = (led == LAST_LED) ? FIRST_LED : led + 3'd1;
    lvl      = st.level;
    sum      = {1'b0, lvl} + {1'b0, s};
    fall_end = ({1'b0, lvl} <= low_s);

    // one ramp move: rise to full, then fall back to the low level
    if (st.rising) begin
      adv_level  = (sum >= {1'b0, FULL_LEVEL}) ? FULL_LEVEL : sum[7:0];
      adv_rising = (sum < {1'b0, FULL_LEVEL});
      adv_done   = 1'b0;
    end else if (fall_end) begin
      adv_level  = LOW_LEVEL;
      adv_rising = 1'b1;
      adv_done   = 1'b1;
    end else begin
      adv_level  = lvl - s;
      adv_rising = 1'b0;
      adv_done   = 1'b0;
    end

    nxt      = st;
    fire     = 1'b0;
    out_led  = led;
    out_duty = lvl;
    out_end  = 1'b0;

    if (st.countdown != 16'd0) begin
      nxt.countdown = st.countdown - 16'd1;
    end else begin
      fire          = 1'b1;
      nxt.countdown = (cfg.delay_ticks == 16'd0) ? 16'd0 : cfg.delay_ticks - 16'd1;
      case (cfg.mode)
        MODE_BLINK: begin
          out_end = !st.rising && (led == LAST_LED) && fall_end;
          nxt.led = led_wrap;
          if (led == LAST_LED) begin
            nxt.level  = adv_level;
            nxt.rising = adv_rising;
          end
        end
        MODE_SNAKE: begin
          out_end    = adv_done && st.section && (led == SNAKE_STOP);
          nxt.led    = led;
          nxt.level  = adv_level;
          nxt.rising = adv_rising;
          if (adv_done) begin
            if (!st.section) begin
              if (led < LAST_LED) begin
                nxt.led = led + 3'd1;
              end else begin
                nxt.section = 1'b1;
                nxt.led     = SNAKE_TURN;
              end
            end else begin
              if (led > SNAKE_STOP) begin
                nxt.led = led - 3'd1;
              end else begin
                nxt.section = 1'b0;
                nxt.led     = FIRST_LED;
              end
            end
          end
        end
        MODE_XFADE: begin
          nxt.led = led;
          if (!st.second) begin
            nxt.second = 1'b1;
          end else begin
            out_led    = led_wrap;
            out_duty   = FULL_LEVEL - lvl;
            out_end    = (lvl < s) && (led == LAST_LED);
            nxt.second = 1'b0;
            if (lvl < s) begin
              nxt.level = FULL_LEVEL;
              nxt.led   = led_wrap;
            end else begin
              nxt.level = lvl - s;
            end
          end
        end
        default: begin
          out_duty = cfg.circle_level;
          out_end  = (led == LAST_LED);
          nxt.led  = led_wrap;
        end
      endcase
    end

    res.segment_index = out_led;
    res.duty          = out_duty;
    res.pins          = pin_map(out_led);
    res.pass_end      = out_end;
  end

endmodule

// ===== rtl/charlieplex_led_effect_sequencer_unit.sv =====
// Top level of the charlieplex LED effect sequencer: state, result register, APB port.
//
// Usage
//   Slave stream (s_*): one transfer is one time tick; s_tdata bit 0 is restart.
//   Master stream (m_*): one transfer per emitted lighting step for six LEDs on
//   three pins: LED index, PWM duty and the drive of each pin; m_tlast marks the
//   last step of a full effect pass.
//   APB port: effect_mode at 0x0, level_step at 0x4, delay_ticks at 0x8,
//   circle_level at 0xC. Write registers only while the streams are idle.
//   Writing effect_mode restarts the effect position but keeps the tick count.
// Timing
//   A tick that emits a step shows its result in the cycle after its transfer.
//   One tick per cycle is taken unless the step stream stalls: the whole sequencer
//   update is one pass of logic between the state registers and the result register.
//   A step is emitted on a tick whose countdown is zero, then delay_ticks - 1 ticks
//   pass before the next one, none for zero (restart clears the countdown at once).
// Reset and stall
//   Reset empties the result register and starts cross-fade mode at full level.
//   While a result waits and m_tready is low, s_tready drops and ticks hold.
module charlieplex_led_effect_sequencer_unit
  import cles_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // tick stream
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [7:0]              s_tdata,   // [0] restart, [7:1] zero
  // step stream
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [23:0]             m_tdata,   // [2:0] segment_index, [10:3] duty,
                                             // [12:11] pin_a_drive, [14:13] pin_b_drive,
                                             // [16:15] pin_c_drive, [23:17] zero
  output logic                    m_tlast,   // pass_end
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output logic [ApbDataWidth-1:0] prdata,
  output logic                    pready
);

  cfg_t       cfg;
  seq_state_t state;
  seq_state_t state_next;
  seq_state_t mode_start;
  result_t    step_res;
  result_t    out_res;
  logic       fire;
  logic       accept;

  cles_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cles_step u_step (
    .cur     (state),
    .cfg     (cfg),
    .restart (s_tdata[0]),
    .nxt     (state_next),
    .fire    (fire),
    .res     (step_res)
  );

  // take a tick whenever the result register is empty or being drained
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // a mode write restarts the effect but keeps the tick countdown
  always_comb begin
    mode_start           = restart_state(cfg.mode_new);
    mode_start.countdown = state.countdown;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= restart_state(MODE_XFADE);
    end else if (accept) begin
      state <= state_next;
    end else if (cfg.mode_wr) begin
      state <= mode_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= fire;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // load the result only for ticks that emit a step
  always_ff @(posedge clk) begin
    if (accept && fire) begin
      out_res <= step_res;
    end
  end

  assign m_tdata = {7'd0, out_res.pins.c, out_res.pins.b, out_res.pins.a,
                    out_res.duty, out_res.segment_index};
  assign m_tlast = out_res.pass_end;

`ifndef ASSERT_OFF
  a_led_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] >= FIRST_LED) && (m_tdata[2:0] <= LAST_LED))
    else $error("segment index out of range");

  a_one_pwm: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones({m_tdata[12:11] == DRV_PWM, m_tdata[14:13] == DRV_PWM,
                             m_tdata[16:15] == DRV_PWM}) == 1)
    else $error("not exactly one PWM pin");

  a_restart_emits: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tdata[0]) |=> m_tvalid)
    else $error("restart tick gave no step");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("tick stalled with empty result register");
`endif

endmodule

// ===== bench/tb_charlieplex_led_effect_sequencer_unit.sv =====
// Self-checking testbench for the charlieplex LED effect sequencer: tick stream in, steps out.
module tb_charlieplex_led_effect_sequencer_unit
  import cles_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 4000;  // cycles with no transfer before giving up
  localparam int TICK_TARGET = 1500;  // directed plus random ticks
  localparam int REPORT_CAP  = 40;    // print at most this many mismatch lines

  logic                    clk      = 1'b0;
  logic                    rst      = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [7:0]              s_tdata  = '0;   // [0] restart, [7:1] zero
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [23:0]             m_tdata;         // [2:0] segment_index, [10:3] duty,
                                            // [12:11] pin_a, [14:13] pin_b,
                                            // [16:15] pin_c, [23:17] zero
  logic                    m_tlast;         // pass_end
  logic                    psel     = 1'b0;
  logic                    penable  = 1'b0;
  logic                    pwrite   = 1'b0;
  logic [ApbAddrWidth-1:0] paddr    = '0;
  logic [ApbDataWidth-1:0] pwdata   = '0;
  logic [ApbDataWidth-1:0] prdata;
  logic                    pready;

  charlieplex_led_effect_sequencer_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // ---------------------------------------------------------------------------
  // Sequencer predictor: own copy of the registers and the effect position.
  // ---------------------------------------------------------------------------
  mode_t       cfg_mode;
  logic [7:0]  cfg_step;
  logic [15:0] cfg_delay;
  logic [7:0]  cfg_circle;

  logic [15:0] pr_countdown;
  logic        pr_section;   // snake: 0 forward over 1..6, 1 backward over 5..2
  logic [2:0]  pr_led;
  logic [8:0]  pr_level;     // one bit of headroom above full level while ramping
  logic        pr_rising;
  logic        pr_second;    // cross-fade: the next LED's half is due

  result_t     pending_steps[$];
  bit          tick_backlog[$];

  int ticks_queued   = 0;
  int ticks_accepted = 0;
  int steps_checked  = 0;
  int passes_seen    = 0;
  int settings_used  = 0;
  int mismatches     = 0;
  int mode_steps[4]  = '{0, 0, 0, 0};
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int quiet_cycles   = 0;

  function automatic void restart_position();
    pr_section = 1'b0;
    pr_led     = FIRST_LED;
    pr_level   = (cfg_mode == MODE_XFADE) ? 9'(FULL_LEVEL) : 9'(LOW_LEVEL);
    pr_rising  = 1'b1;
    pr_second  = 1'b0;
  endfunction

  function automatic void reset_sequencer();
    cfg_mode     = MODE_XFADE;
    cfg_step     = 8'd1;
    cfg_delay    = 16'd2;
    cfg_circle   = 8'd255;
    pr_countdown = '0;
    restart_position();
  endfunction

  function automatic void apply_register(reg_idx_t idx, logic [31:0] value);
    case (idx)
      REG_MODE: begin
        // a mode write restarts the effect but leaves the countdown alone
        cfg_mode = mode_t'(value[1:0]);
        restart_position();
      end
      REG_STEP:   cfg_step   = value[7:0];
      REG_DELAY:  cfg_delay  = value[15:0];
      REG_CIRCLE: cfg_circle = value[7:0];
      default: ;
    endcase
  endfunction

  // Pin drives of each LED on the three shared pins.
  function automatic pins_t drive_for(logic [2:0] led);
    pins_t p;
    case (led)
      3'd2:    begin p.a = DRV_PWM; p.b = DRV_LOW; p.c = DRV_HIZ; end
      3'd3:    begin p.a = DRV_HIZ; p.b = DRV_LOW; p.c = DRV_PWM; end
      3'd4:    begin p.a = DRV_HIZ; p.b = DRV_PWM; p.c = DRV_LOW; end
      3'd5:    begin p.a = DRV_LOW; p.b = DRV_HIZ; p.c = DRV_PWM; end
      3'd6:    begin p.a = DRV_PWM; p.b = DRV_HIZ; p.c = DRV_LOW; end
      default: begin p.a = DRV_LOW; p.b = DRV_PWM; p.c = DRV_HIZ; end
    endcase
    return p;
  endfunction

  function automatic result_t step_result(logic [2:0] led, logic [7:0] duty, bit closes_pass);
    result_t r;
    r.segment_index = led;
    r.duty          = duty;
    r.pins          = drive_for(led);
    r.pass_end      = closes_pass;
    return r;
  endfunction

  // Move the ramp one notch; true when a full up-down ramp has just ended.
  function automatic bit ramp_move(logic [7:0] s);
    logic [9:0] floor_lvl;
    floor_lvl = 10'(LOW_LEVEL) + 10'(s);
    if (pr_rising) begin
      pr_level = pr_level + 9'(s);
      if (pr_level >= 9'(FULL_LEVEL)) begin
        pr_level  = 9'(FULL_LEVEL);
        pr_rising = 1'b0;
      end
      return 1'b0;
    end
    if (10'(pr_level) <= floor_lvl) begin
      pr_level  = 9'(LOW_LEVEL);
      pr_rising = 1'b1;
      return 1'b1;
    end
    pr_level = pr_level - 9'(s);
    return 1'b0;
  endfunction

  // One tick: returns 1 and the lighting step when the tick emits one.
  function automatic bit advance_sequencer(bit restart_in, output result_t res);
    logic [7:0] s;
    logic [2:0] led;
    logic [2:0] nxt;
    logic [8:0] lvl;
    logic [9:0] floor_lvl;
    bit         last;
    res = '0;
    if (restart_in) begin
      restart_position();
      pr_countdown = '0;
    end
    if (pr_countdown != 0) begin
      pr_countdown = pr_countdown - 16'd1;
      return 1'b0;
    end
    s         = (cfg_step == 8'd0) ? 8'd1 : cfg_step;  // zero step acts as one
    led       = (pr_led < FIRST_LED || pr_led > LAST_LED) ? FIRST_LED : pr_led;
    lvl       = pr_level;
    floor_lvl = 10'(LOW_LEVEL) + 10'(s);
    mode_steps[cfg_mode]++;
    case (cfg_mode)
      MODE_BLINK: begin
        res = step_result(led, lvl[7:0],
                          !pr_rising && led == LAST_LED && 10'(lvl) <= floor_lvl);
        if (led < LAST_LED) begin
          pr_led = led + 3'd1;
        end else begin
          pr_led = FIRST_LED;
          void'(ramp_move(s));
        end
      end
      MODE_SNAKE: begin
        res = step_result(led, lvl[7:0], !pr_rising && 10'(lvl) <= floor_lvl &&
                          pr_section && led == SNAKE_STOP);
        pr_led = led;
        if (ramp_move(s)) begin
          if (!pr_section) begin
            if (led < LAST_LED) begin
              pr_led = led + 3'd1;
            end else begin
              pr_section = 1'b1;
              pr_led     = SNAKE_TURN;
            end
          end else begin
            if (led > SNAKE_STOP) begin
              pr_led = led - 3'd1;
            end else begin
              pr_section = 1'b0;
              pr_led     = FIRST_LED;
            end
          end
        end
      end
      MODE_XFADE: begin
        if (lvl > 9'(FULL_LEVEL)) lvl = 9'(FULL_LEVEL);
        if (!pr_second) begin
          res       = step_result(led, lvl[7:0], 1'b0);
          pr_led    = led;
          pr_level  = lvl;
          pr_second = 1'b1;
        end else begin
          nxt       = (led == LAST_LED) ? FIRST_LED : led + 3'd1;
          last      = lvl < 9'(s);
          res       = step_result(nxt, FULL_LEVEL - lvl[7:0], last && led == LAST_LED);
          pr_second = 1'b0;
          if (last) begin
            pr_level = 9'(FULL_LEVEL);
            pr_led   = nxt;
          end else begin
            pr_level = lvl - 9'(s);
            pr_led   = led;
          end
        end
      end
      default: begin
        res    = step_result(led, cfg_circle, led == LAST_LED);
        pr_led = (led == LAST_LED) ? FIRST_LED : led + 3'd1;
      end
    endcase
    // zero delay acts as one: a step on every tick
    pr_countdown = ((cfg_delay == 16'd0) ? 16'd1 : cfg_delay) - 16'd1;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and reset.
  // ---------------------------------------------------------------------------
  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Tick driver: feed transfers from the backlog, idle at random, and predict
  // each accepted tick at the edge that takes it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        ticks_accepted++;
        if (advance_sequencer(s_tdata[0], r)) pending_steps.push_back(r);
      end
      // load the next tick only once the current one is gone
      if (!s_tvalid || s_tready) begin
        if (tick_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata  <= {7'd0, tick_backlog.pop_front()};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Step monitor: compare every accepted step with the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < REPORT_CAP)
      $display("%0t ns: step %0d %s: got %0h, expected %0h",
               $realtime, steps_checked, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_steps.size() == 0) begin
          flag_mismatch("arrived with nothing pending", 32'(m_tdata), 32'd0);
        end else begin
          want = pending_steps.pop_front();
          if (m_tdata[2:0] !== want.segment_index)
            flag_mismatch("segment_index", 32'(m_tdata[2:0]), 32'(want.segment_index));
          if (m_tdata[10:3] !== want.duty)
            flag_mismatch("duty", 32'(m_tdata[10:3]), 32'(want.duty));
          if (m_tdata[12:11] !== want.pins.a)
            flag_mismatch("pin_a_drive", 32'(m_tdata[12:11]), 32'(want.pins.a));
          if (m_tdata[14:13] !== want.pins.b)
            flag_mismatch("pin_b_drive", 32'(m_tdata[14:13]), 32'(want.pins.b));
          if (m_tdata[16:15] !== want.pins.c)
            flag_mismatch("pin_c_drive", 32'(m_tdata[16:15]), 32'(want.pins.c));
          if (m_tlast !== want.pass_end)
            flag_mismatch("pass_end", 32'(m_tlast), 32'(want.pass_end));
          if (want.pass_end) passes_seen++;
        end
        steps_checked++;
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run after too long without any transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: %0d quiet cycles, %0d steps still pending",
               quiet_cycles, pending_steps.size());
      $display("tb_charlieplex_led_effect_sequencer_unit: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_tick(bit restart_in);
    tick_backlog.push_back(restart_in);
    ticks_queued++;
  endtask

  // Wait until every tick is taken and every step is back, then let the
  // pipeline drain so a register write lands on an idle block.
  task automatic settle();
    while (ticks_accepted != ticks_queued || pending_steps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup cycle, access cycle; the register takes the value at the access edge.
  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    apply_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Pick a fresh setting: mostly coarse steps and short delays so that full
  // passes come around often, with fine steps and zero values mixed in.
  task automatic shuffle_settings();
    logic [7:0]  step_val;
    logic [15:0] delay_val;
    case ($urandom_range(3))
      0:       step_val = 8'($urandom_range(0, 15));
      3:       step_val = $urandom_range(1) ? 8'd255 : 8'd1;
      default: step_val = 8'($urandom_range(16, 255));
    endcase
    case ($urandom_range(7))
      0:       delay_val = 16'd0;
      6:       delay_val = 16'($urandom_range(4, 12));
      7:       delay_val = 16'd1;
      default: delay_val = 16'($urandom_range(1, 3));
    endcase
    if ($urandom_range(1)) reg_write(REG_CIRCLE, $urandom_range(255));
    if ($urandom_range(1)) reg_write(REG_DELAY, 32'(delay_val));
    if ($urandom_range(1)) reg_write(REG_STEP, 32'(step_val));
    if ($urandom_range(3) != 0) reg_write(REG_MODE, $urandom_range(3));
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int restart_pct;
    reset_sequencer();
    send_idle_pct = 35;
    recv_idle_pct = 75;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: cross-fade at full level, a step on every other tick.
    repeat (3) queue_tick(1'b0);
    settle();

    // Zero delay and zero step; the mode write keeps the pending countdown.
    reg_write(REG_DELAY, 32'd0);
    reg_write(REG_STEP, 32'd0);
    reg_write(REG_MODE, 32'(MODE_SNAKE));
    repeat (2) queue_tick(1'b0);
    queue_tick(1'b1);
    queue_tick(1'b0);
    settle();

    // Widest delay and step, darkest circle level; restart cuts the long wait.
    reg_write(REG_DELAY, 32'd65535);
    reg_write(REG_STEP, 32'd255);
    reg_write(REG_CIRCLE, 32'd0);
    reg_write(REG_MODE, 32'(MODE_BLINK));
    repeat (3) queue_tick(1'b0);
    queue_tick(1'b1);
    settle();

    // One whole circle pass at level zero.
    reg_write(REG_MODE, 32'(MODE_CIRCLE));
    reg_write(REG_DELAY, 32'd1);
    queue_tick(1'b1);
    repeat (6) queue_tick(1'b0);
    settle();

    // Back to full circle level and the cross-fade with the coarsest step.
    reg_write(REG_CIRCLE, 32'd255);
    reg_write(REG_MODE, 32'(MODE_XFADE));
    repeat (3) queue_tick(1'b0);
    settle();
    settings_used = 5;

    // Random phases: long runs of plain ticks with rare restarts walk the
    // effects through whole passes; some phases hammer restart instead.
    while (ticks_queued < TICK_TARGET) begin
      if (ticks_queued < TICK_TARGET / 3) begin
        send_idle_pct = 35;
        recv_idle_pct = 75;
      end else if (ticks_queued < 2 * TICK_TARGET / 3) begin
        send_idle_pct = 75;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      shuffle_settings();
      restart_pct = ($urandom_range(3) == 0) ? 20 : 1;
      repeat ($urandom_range(60, 140)) queue_tick($urandom_range(99) < restart_pct);
      settle();
    end
    repeat (6) @(posedge clk);

    $display("ran %0d ticks over %0d register settings; %0d steps checked, %0d full passes",
             ticks_accepted, settings_used, steps_checked, passes_seen);
    $display("steps per effect: blink %0d, snake %0d, cross-fade %0d, circle %0d",
             mode_steps[0], mode_steps[1], mode_steps[2], mode_steps[3]);
    if (mismatches == 0 && pending_steps.size() == 0) begin
      $display("tb_charlieplex_led_effect_sequencer_unit: done, clean");
    end else begin
      $display("tb_charlieplex_led_effect_sequencer_unit: done, errors");
    end
    $finish;
  end

endmodule
